[design/segment_color_statistics_defines.svh]
// Assertion macros for the segment colour statistics block.
// Included by every file that carries assertions; no other dependencies.
`ifndef SEGMENT_COLOR_STATISTICS_DEFINES_SVH
`define SEGMENT_COLOR_STATISTICS_DEFINES_SVH
`ifndef ASSERT_OFF
`define SCS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define SCS_ASSERT_NORST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SCS_ASSERT(lbl, clk, rst_n, prop)
`define SCS_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

[design/scs_pkg.sv]
// Shared types and constants for the segment colour statistics block.
// No dependencies.
package scs_pkg;

    localparam int LABEL_W = 10;
    localparam int MASK_W  = 16;
    localparam int L_W     = 15;
    localparam int CH_W    = 16;
    localparam int RATIO_W = 9;

    localparam logic signed [MASK_W-1:0] MASK_THR_RST = 16'sd256;
    localparam logic [RATIO_W-1:0]       RATIO_RST    = 9'd128;

    typedef enum logic [1:0] {
        REQ_PIXEL = 2'd0,
        REQ_QUERY = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic {
        CFG_MASK_THR = 1'b0,
        CFG_RATIO    = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_RUN,
        ST_QRY,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

[design/segment_color_statistics.sv]
// Segment colour statistics: pixel requests are taken back to back, one per cycle
// while o_stall is low, with a read-modify-write over the segment RAM and
// forwarding of the previous write. Query: the averages come from the bit-serial
// divider, used once per channel; a query of an invalid segment skips the divider.
// Reset and clear requests sweep the RAM with input stalled.
// Depends on scs_pkg, scs_ram, scs_div and segment_color_statistics_defines.svh.
`include "segment_color_statistics_defines.svh"
module segment_color_statistics #(
    parameter int MAX_SEGMENTS = 1024,
    parameter int COUNT_BITS   = 22
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_req_type,
    input  logic [9:0]            i_seg_label,
    input  logic signed [15:0]    i_mask_value,
    input  logic [14:0]           i_pixel_l,
    input  logic signed [15:0]    i_pixel_a,
    input  logic signed [15:0]    i_pixel_b,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_seg_valid,
    output logic [COUNT_BITS-1:0] o_seg_weight,
    output logic [COUNT_BITS-1:0] o_seg_total,
    output logic [14:0]           o_avg_l,
    output logic signed [15:0]    o_avg_a,
    output logic signed [15:0]    o_avg_b,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [15:0]           i_cfg_data
);
    localparam int CB    = COUNT_BITS;
    localparam int AW    = $clog2(MAX_SEGMENTS);
    localparam int SL_W  = scs_pkg::L_W + CB;
    localparam int SA_W  = scs_pkg::CH_W + CB;
    localparam int ENT_W = 2 * CB + SL_W + 2 * SA_W;
    localparam logic [CB-1:0] CNT_MAX = '1;

    scs_pkg::t_state r_state, n_state;

    logic signed [15:0] r_mask_thr;
    logic [8:0]         r_ratio;

    // stage 2: request whose entry is being read
    logic               r_s2_vld;
    scs_pkg::t_req      r_s2_req;
    logic [AW-1:0]      r_s2_addr;
    logic               r_s2_inr;
    logic signed [15:0] r_s2_mask;
    logic [14:0]        r_s2_l;
    logic signed [15:0] r_s2_a;
    logic signed [15:0] r_s2_b;

    logic               r_wr_vld;
    logic [AW-1:0]      r_wr_addr;
    logic [ENT_W-1:0]   r_wr_data;

    logic [AW-1:0]      r_clr_addr;

    logic [CB-1:0]          r_q_v, r_q_t;
    logic [SL_W-1:0]        r_q_sl;
    logic signed [SA_W-1:0] r_q_sa, r_q_sb;
    logic                   r_q_ok;
    logic [1:0]             r_ch;
    logic                   r_div_start;
    logic [14:0]            r_avg_l;
    logic [15:0]            r_avg_a, r_avg_b;

    logic                  r_out_vld;
    logic                  r_out_sv;
    logic [CB-1:0]         r_out_w, r_out_t;
    logic [14:0]           r_out_l;
    logic [15:0]           r_out_a, r_out_b;

    logic                   accept;
    logic                   in_range;
    logic [AW-1:0]          in_addr;
    logic [ENT_W-1:0]       ram_rdata, ent, ram_wdata, new_ent;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [CB-1:0]          e_t, e_v, t_new, v_new;
    logic [SL_W-1:0]        e_sl, sl_new;
    logic signed [SA_W-1:0] e_sa, e_sb, sa_new, sb_new;
    logic                   hit;
    logic                   pix_wr;
    logic [CB+8:0]          lhs, rhs;
    logic                   div_done;
    logic [SA_W-1:0]        div_quot;
    logic signed [SA_W-1:0] div_dvd;
    logic                   clr_last;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_thr <= scs_pkg::MASK_THR_RST;
            r_ratio    <= scs_pkg::RATIO_RST;
        end else if (i_cfg_valid) begin
            unique case (scs_pkg::t_cfg_idx'(i_cfg_index))
                scs_pkg::CFG_MASK_THR: r_mask_thr <= i_cfg_data;
                scs_pkg::CFG_RATIO:    r_ratio    <= i_cfg_data[8:0];
                default:               r_ratio    <= r_ratio;
            endcase
        end
    end

    assign in_range = 32'(i_seg_label) < 32'(MAX_SEGMENTS);
    assign in_addr  = AW'(32'(i_seg_label));
    assign accept   = i_valid && !o_stall;
    assign clr_last = r_clr_addr == AW'(MAX_SEGMENTS - 1);

    // entry as read, with the previous cycle's write forwarded
    assign ent = (r_wr_vld && r_wr_addr == r_s2_addr) ? r_wr_data : ram_rdata;
    assign {e_t, e_v, e_sl, e_sa, e_sb} = ent;

    always_comb begin
        hit    = (r_s2_mask > r_mask_thr) && (e_v != CNT_MAX);
        t_new  = (e_t == CNT_MAX) ? e_t : e_t + CB'(1);
        v_new  = hit ? e_v + CB'(1) : e_v;
        sl_new = hit ? e_sl + SL_W'(r_s2_l) : e_sl;
        sa_new = hit ? e_sa + SA_W'(r_s2_a) : e_sa;
        sb_new = hit ? e_sb + SA_W'(r_s2_b) : e_sb;
        new_ent = {t_new, v_new, sl_new, sa_new, sb_new};
        lhs = {1'b0, e_v, 8'd0};
        rhs = (CB+9)'(r_ratio) * (CB+9)'(e_t);
    end

    assign pix_wr = r_s2_vld && r_s2_req == scs_pkg::REQ_PIXEL && r_s2_inr;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            scs_pkg::ST_CLR: if (clr_last) n_state = scs_pkg::ST_RUN;
            scs_pkg::ST_RUN: begin
                if (accept && i_req_type == scs_pkg::REQ_QUERY) n_state = scs_pkg::ST_QRY;
                else if (accept && i_req_type == scs_pkg::REQ_CLEAR) n_state = scs_pkg::ST_CLR;
            end
            scs_pkg::ST_QRY: begin
                if (r_s2_inr && e_v != '0 && lhs > rhs) n_state = scs_pkg::ST_DIV;
                else n_state = scs_pkg::ST_OUT;
            end
            scs_pkg::ST_DIV: if (div_done && r_ch == 2'd2) n_state = scs_pkg::ST_OUT;
            scs_pkg::ST_OUT: n_state = scs_pkg::ST_RUN;
            default: n_state = scs_pkg::ST_CLR;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_stall   = (r_state != scs_pkg::ST_RUN)
                    || (r_out_vld && i_req_type == scs_pkg::REQ_QUERY);
        ram_we    = 1'b0;
        ram_waddr = r_s2_addr;
        ram_wdata = new_ent;
        if (r_state == scs_pkg::ST_CLR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (pix_wr) begin
            ram_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= scs_pkg::ST_CLR;
            r_clr_addr  <= '0;
            r_s2_vld    <= 1'b0;
            r_wr_vld    <= 1'b0;
            r_div_start <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_s2_vld    <= accept;
            r_wr_vld    <= pix_wr && r_state != scs_pkg::ST_CLR;
            r_div_start <= 1'b0;
            if (r_state == scs_pkg::ST_CLR) r_clr_addr <= r_clr_addr + AW'(1);
            else r_clr_addr <= '0;
            if (n_state == scs_pkg::ST_DIV && r_state == scs_pkg::ST_QRY) r_div_start <= 1'b1;
            if (r_state == scs_pkg::ST_DIV && div_done && r_ch != 2'd2) r_div_start <= 1'b1;
            if (r_state == scs_pkg::ST_OUT) r_out_vld <= 1'b1;
            else if (!i_stall) r_out_vld <= 1'b0;
        end
        if (accept) begin
            r_s2_req  <= scs_pkg::t_req'(i_req_type);
            r_s2_addr <= in_addr;
            r_s2_inr  <= in_range;
            r_s2_mask <= i_mask_value;
            r_s2_l    <= i_pixel_l;
            r_s2_a    <= i_pixel_a;
            r_s2_b    <= i_pixel_b;
        end
        r_wr_addr <= r_s2_addr;
        r_wr_data <= new_ent;
        if (r_state == scs_pkg::ST_QRY) begin
            r_q_v   <= r_s2_inr ? e_v : '0;
            r_q_t   <= r_s2_inr ? e_t : '0;
            r_q_sl  <= e_sl;
            r_q_sa  <= e_sa;
            r_q_sb  <= e_sb;
            r_q_ok  <= n_state == scs_pkg::ST_DIV;
            r_ch    <= 2'd0;
            r_avg_l <= '0;
            r_avg_a <= '0;
            r_avg_b <= '0;
        end
        if (r_state == scs_pkg::ST_DIV && div_done) begin
            r_ch <= r_ch + 2'd1;
            case (r_ch)
                2'd0:    r_avg_l <= div_quot[14:0];
                2'd1:    r_avg_a <= div_quot[15:0];
                default: r_avg_b <= div_quot[15:0];
            endcase
        end
        if (r_state == scs_pkg::ST_OUT) begin
            r_out_sv <= r_q_ok;
            r_out_w  <= r_q_v;
            r_out_t  <= r_q_t;
            r_out_l  <= r_avg_l;
            r_out_a  <= r_avg_a;
            r_out_b  <= r_avg_b;
        end
    end

    always_comb begin
        case (r_ch)
            2'd0:    div_dvd = SA_W'(r_q_sl);
            2'd1:    div_dvd = r_q_sa;
            default: div_dvd = r_q_sb;
        endcase
    end

    scs_ram #(.W(ENT_W), .D(MAX_SEGMENTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    scs_div #(.DW(SA_W), .CW(CB)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (div_dvd),
        .i_divisor  (r_q_v),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign o_valid      = r_out_vld;
    assign o_seg_valid  = r_out_sv;
    assign o_seg_weight = r_out_w;
    assign o_seg_total  = r_out_t;
    assign o_avg_l      = r_out_l;
    assign o_avg_a      = r_out_a;
    assign o_avg_b      = r_out_b;

    `SCS_ASSERT(a_no_accept_busy, i_clk, i_rst_n, accept |-> r_state == scs_pkg::ST_RUN)
    `SCS_ASSERT(a_clr_writes, i_clk, i_rst_n, r_state == scs_pkg::ST_CLR |-> ram_we && ram_wdata == '0)
    `SCS_ASSERT(a_out_follows, i_clk, i_rst_n, r_state == scs_pkg::ST_OUT |=> r_out_vld)
    `SCS_ASSERT(a_div_in_div, i_clk, i_rst_n, r_div_start |-> r_state == scs_pkg::ST_DIV)
endmodule

[design/scs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
module scs_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[design/scs_div.sv]
// Radix-2 restoring divider: signed dividend by unsigned non-zero divisor,
// quotient truncated toward zero, one bit per cycle. No dependencies.
module scs_div #(
    parameter int DW = 38,
    parameter int CW = 22
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [DW-1:0] i_dividend,
    input  logic [CW-1:0]        i_divisor,
    output logic                 o_done,
    output logic [DW-1:0]        o_quot
);
    localparam int CNT_W = $clog2(DW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [CW-1:0]    r_rem;
    logic [DW-1:0]    r_q;
    logic             r_neg;
    logic [CW-1:0]    r_div;
    logic [CW:0]      trial;
    logic [CW:0]      diff;
    logic             ge;

    always_comb begin
        trial = {r_rem, r_q[DW-1]};
        ge    = trial >= {1'b0, r_div};
        diff  = trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_cnt <= CNT_W'(DW - 1);
            r_rem <= '0;
            r_neg <= i_dividend[DW-1];
            r_div <= i_divisor;
            r_q   <= i_dividend[DW-1] ? (~i_dividend + DW'(1)) : i_dividend;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            r_q   <= {r_q[DW-2:0], ge};
            r_rem <= ge ? diff[CW-1:0] : trial[CW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (~r_q + DW'(1)) : r_q;
endmodule

[verif/scs_checker.sv]
// Checker for segment_color_statistics: watches the pixel, result and register channels,
// keeps its own per-segment statistics and compares every query result in order.
// Depends on scs_pkg.
module scs_checker (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic                     i_in_stall,
    input  scs_pkg::t_req            i_req_type,
    input  logic [9:0]               i_seg_label,
    input  logic signed [15:0]       i_mask_value,
    input  logic [14:0]              i_pixel_l,
    input  logic signed [15:0]       i_pixel_a,
    input  logic signed [15:0]       i_pixel_b,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic                     i_seg_valid,
    input  logic [21:0]              i_seg_weight,
    input  logic [21:0]              i_seg_total,
    input  logic [14:0]              i_avg_l,
    input  logic signed [15:0]       i_avg_a,
    input  logic signed [15:0]       i_avg_b,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  scs_pkg::t_cfg_idx        i_cfg_index,
    input  logic [15:0]              i_cfg_data,
    output int                       o_fail_count,
    output int                       o_pending
);
    localparam int NSEG = 1024;
    localparam longint CNT_MAX = (64'd1 << 22) - 1;

    typedef struct packed {
        logic               valid;
        logic [21:0]        weight;
        logic [21:0]        total;
        logic [14:0]        l;
        logic signed [15:0] a;
        logic signed [15:0] b;
    } t_stats;

    longint lum_sum [NSEG];
    longint a_sum   [NSEG];
    longint b_sum   [NSEG];
    longint masked_cnt [NSEG];
    longint pixel_cnt  [NSEG];
    logic signed [15:0] mask_thr;
    logic [8:0]         ratio;
    t_stats             stats_due[$];

    task automatic wipe_segments();
        for (int i = 0; i < NSEG; i++) begin
            lum_sum[i] = 0;
            a_sum[i] = 0;
            b_sum[i] = 0;
            masked_cnt[i] = 0;
            pixel_cnt[i] = 0;
        end
    endtask

    function automatic t_stats segment_stats(int lab);
        t_stats r;
        longint v;
        longint t;
        r = '0;
        v = masked_cnt[lab];
        t = pixel_cnt[lab];
        r.weight = v[21:0];
        r.total = t[21:0];
        if (v * 256 > longint'(ratio) * t && v > 0) begin
            r.valid = 1'b1;
            r.l = 15'(lum_sum[lab] / v);
            r.a = 16'(a_sum[lab] / v);
            r.b = 16'(b_sum[lab] / v);
        end
        return r;
    endfunction

    assign o_pending = stats_due.size();

    always @(posedge i_clk) begin
        t_stats got;
        t_stats want;
        int lab;
        if (!i_rst_n) begin
            wipe_segments();
            mask_thr = scs_pkg::MASK_THR_RST;
            ratio = scs_pkg::RATIO_RST;
            stats_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == scs_pkg::CFG_MASK_THR)
                    mask_thr = i_cfg_data;
                else
                    ratio = i_cfg_data[8:0];
            end
            if (i_valid && !i_in_stall) begin
                lab = i_seg_label;
                case (i_req_type)
                    scs_pkg::REQ_PIXEL: begin
                        if (pixel_cnt[lab] < CNT_MAX)
                            pixel_cnt[lab]++;
                        if (i_mask_value > mask_thr && masked_cnt[lab] < CNT_MAX) begin
                            masked_cnt[lab]++;
                            lum_sum[lab] += longint'(i_pixel_l);
                            a_sum[lab] += longint'(i_pixel_a);
                            b_sum[lab] += longint'(i_pixel_b);
                        end
                    end
                    scs_pkg::REQ_QUERY: stats_due = {stats_due, segment_stats(lab)};
                    scs_pkg::REQ_CLEAR: wipe_segments();
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got = {i_seg_valid, i_seg_weight, i_seg_total, i_avg_l, i_avg_a, i_avg_b};
                if (stats_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result: %p", got);
                end else begin
                    want = stats_due.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("result mismatch: expected %p, actual %p", want, got);
                    end
                end
            end
        end
    end
endmodule

[verif/tb_segment_color_statistics.sv]
// Testbench top for segment_color_statistics: drives pixel, query and clear requests
// plus register writes through several idling phases; checking lives in scs_checker.
// Depends on scs_pkg, scs_checker and the block itself.
module tb_segment_color_statistics;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 1300;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    scs_pkg::t_req      i_req_type = scs_pkg::REQ_NONE;
    logic [9:0]         i_seg_label = '0;
    logic signed [15:0] i_mask_value = '0;
    logic [14:0]        i_pixel_l = '0;
    logic signed [15:0] i_pixel_a = '0;
    logic signed [15:0] i_pixel_b = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic               o_seg_valid;
    logic [21:0]        o_seg_weight;
    logic [21:0]        o_seg_total;
    logic [14:0]        o_avg_l;
    logic signed [15:0] o_avg_a;
    logic signed [15:0] o_avg_b;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    scs_pkg::t_cfg_idx  i_cfg_index = scs_pkg::CFG_MASK_THR;
    logic [15:0]        i_cfg_data = '0;

    int fail_count;
    int stats_pending;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    logic signed [15:0] cur_thr = scs_pkg::MASK_THR_RST;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    segment_color_statistics dut (.*);

    scs_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_req_type, .i_seg_label,
        .i_mask_value, .i_pixel_l, .i_pixel_a, .i_pixel_b,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_seg_valid(o_seg_valid),
        .i_seg_weight(o_seg_weight), .i_seg_total(o_seg_total), .i_avg_l(o_avg_l),
        .i_avg_a(o_avg_a), .i_avg_b(o_avg_b), .i_cfg_valid, .i_cfg_ready(o_cfg_ready),
        .i_cfg_index, .i_cfg_data, .o_fail_count(fail_count), .o_pending(stats_pending)
    );

    always @(posedge i_clk)
        i_stall <= ($urandom_range(0, 99) < stall_pct);

    // nothing moving on any channel for too long means a hang
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send(scs_pkg::t_req req, int lab, int mask, int l, int a, int b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_seg_label  <= 10'(lab);
        i_mask_value <= 16'(mask);
        i_pixel_l    <= 15'(l);
        i_pixel_a    <= 16'(a);
        i_pixel_b    <= 16'(b);
        do @(posedge i_clk); while (o_stall);
    endtask

    // leaves valid high; the caller drops it after the last write
    task automatic write_reg(scs_pkg::t_cfg_idx idx, int data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= 16'(data);
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // let queries drain and any clear sweep finish before touching registers
    task automatic settle();
        i_valid <= 1'b0;
        while (stats_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random();
        int r;
        int lab;
        int mask;
        scs_pkg::t_req req;
        r = $urandom_range(0, 99);
        req = (r < 68) ? scs_pkg::REQ_PIXEL :
              (r < 94) ? scs_pkg::REQ_QUERY :
              (r < 97) ? scs_pkg::REQ_CLEAR : scs_pkg::REQ_NONE;
        lab = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 7) : $urandom_range(0, 1023);
        if ($urandom_range(0, 1))
            mask = cur_thr + $urandom_range(0, 8) - 4;
        else
            mask = $urandom;
        send(req, lab, mask, $urandom_range(0, 25600), $urandom, $urandom);
    endtask

    int thr_set[5]   = '{-32768, 32767, 0, -100, 256};
    int ratio_set[5] = '{0, 256, 511, 64, 128};

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, ties at both thresholds, empty segment, clear
        send(scs_pkg::REQ_QUERY, 0, 0, 0, 0, 0);
        send(scs_pkg::REQ_PIXEL, 0, 32767, 25600, -32768, 32767);
        send(scs_pkg::REQ_PIXEL, 0, -32768, 0, 32767, -32768);
        send(scs_pkg::REQ_PIXEL, 0, 257, 1, -1, 1);
        send(scs_pkg::REQ_PIXEL, 0, 256, 100, 100, 100);
        send(scs_pkg::REQ_QUERY, 0, 0, 0, 0, 0);
        send(scs_pkg::REQ_PIXEL, 1023, 300, 12345, 32767, -32768);
        send(scs_pkg::REQ_QUERY, 1023, -1, 32767, -1, -1);
        send(scs_pkg::REQ_NONE, 1023, 32767, 32767, 32767, 32767);
        send(scs_pkg::REQ_QUERY, 1023, 0, 0, 0, 0);
        send(scs_pkg::REQ_PIXEL, 2, 1000, 3, -3, 5);
        send(scs_pkg::REQ_PIXEL, 2, 1000, 4, -2, 4);
        send(scs_pkg::REQ_QUERY, 2, 0, 0, 0, 0);
        send(scs_pkg::REQ_CLEAR, 0, 0, 0, 0, 0);
        send(scs_pkg::REQ_QUERY, 1023, 0, 0, 0, 0);
        send(scs_pkg::REQ_QUERY, 0, 0, 0, 0, 0);
        send(scs_pkg::REQ_PIXEL, 5, 32767, 25600, 32767, 32767);
        send(scs_pkg::REQ_QUERY, 5, 0, 0, 0, 0);

        for (int p = 0; p < 5; p++) begin
            settle();
            write_reg(scs_pkg::CFG_MASK_THR, thr_set[p]);
            write_reg(scs_pkg::CFG_RATIO, ratio_set[p]);
            i_cfg_valid <= 1'b0;
            cur_thr = 16'(thr_set[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 69; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 69; end
                default: begin send_idle_pct = 12; stall_pct = 12; end
            endcase
            repeat (140) send_random();
        end

        i_valid <= 1'b0;
        while (stats_pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

[sim.f]
+incdir+design
design/scs_pkg.sv
design/scs_ram.sv
design/scs_div.sv
design/segment_color_statistics.sv
verif/scs_checker.sv
verif/tb_segment_color_statistics.sv
